[design/assert_macros.svh]
// Assertion macros shared by the deframer modules.
// Both macros sample on the rising edge of clock and are off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The condition must never be true at a sampled edge.
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_ALWAYS(label, !(cond), msg)

`endif

[design/fcd_pkg.sv]
package fcd_pkg;

   // Cluster buffer geometry.
   localparam int CLUSTER_MAX = 64;
   localparam int POS_W       = $clog2(CLUSTER_MAX);
   localparam int BANKS       = 2;
   localparam int ADDR_W      = POS_W + $clog2(BANKS);
   localparam int HDR_BYTES   = 4;

   // Cluster size register and its usable range.
   localparam int SIZE_W      = 7;
   localparam int SIZE_MIN    = 5;
   localparam int SIZE_HI     = (CLUSTER_MAX < 127) ? CLUSTER_MAX : 127;
   localparam int CMP_W       = SIZE_W + 1;
   localparam int LIMIT_W     = 16;

   // Each bank holds one cluster, so the job queue has one slot per bank.
   localparam int QUEUE_DEPTH = BANKS;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_LIMIT = 1'd1;
   localparam logic [SIZE_W-1:0]    CLUSTER_SIZE_RESET = 7'd16;
   localparam logic [LIMIT_W-1:0]   RECORD_LIMIT_RESET = 16'd16;

   // Input actions.
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_EOS  = 1'b1;

   // Result kinds and status codes.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;
   localparam logic [1:0] ST_COMPLETE = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_EOS      = 2'd2;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  out_byte;
      logic [15:0] record_offset;
      logic [1:0]  status;
      logic [15:0] record_length;
      logic        last;
   } rsp_type;

   // Work handed from the front to the back for one checked cluster or end of stream.
   typedef struct packed {
      logic [$clog2(BANKS)-1:0] bank;
      logic [POS_W-1:0]         copy_cnt;
      logic [15:0]              base_offset;
      logic                     has_status;
      logic [1:0]               status;
      logic [15:0]              length;
   } job_type;

   // Write side of the cluster buffer.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

endpackage

[design/fcd_ram.sv]
module fcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port; the read data register holds until the next read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/fcd_front.sv]
module fcd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fcd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            accept,
   input  fcd_pkg::req_type                req_data,
   output logic                            job_push,
   output fcd_pkg::job_type                job,
   output fcd_pkg::ram_wr_type             ram_wr
);

   // Configuration registers.
   logic [fcd_pkg::SIZE_W-1:0]  cluster_size_ff, cluster_size_in;
   logic [fcd_pkg::LIMIT_W-1:0] record_limit_ff, record_limit_in;

   // Cluster reception and record tracking.
   logic [fcd_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [7:0]                         sum_ff, sum_in;
   logic [7:0]                         exp_index_ff, exp_index_in;
   logic [7:0]                         rec_clusters_ff, rec_clusters_in;
   logic                               in_record_ff, in_record_in;
   logic [15:0]                        gathered_ff, gathered_in;
   logic [$clog2(fcd_pkg::BANKS)-1:0]  bank_ff, bank_in;
   logic [7:0]                         hdr_index_ff, hdr_index_in;
   logic [7:0]                         hdr_count_ff, hdr_count_in;
   logic [7:0]                         hdr_used_ff, hdr_used_in;

   logic [fcd_pkg::SIZE_W-1:0] size_eff;
   logic [fcd_pkg::SIZE_W-1:0] dsize;
   logic [fcd_pkg::CMP_W-1:0]  pos_plus;
   logic [7:0]                 sum_new;
   logic                       cluster_end;
   logic                       used_ok;
   logic                       is_first;
   logic                       is_valid;
   logic                       is_nul;
   logic                       is_last;
   logic                       rec_eff;
   logic [15:0]                base_eff;
   logic [16:0]                room;
   logic                       fits;
   logic                       do_copy;
   logic                       do_over;
   logic                       emit_data;
   logic [15:0]                gathered_after;

   assign csr_ready = 1'b1;

   // Configuration writes.
   always_comb begin
      cluster_size_in = cluster_size_ff;
      record_limit_in = record_limit_ff;
      if (csr_valid) begin
         case (csr_index)
            fcd_pkg::CSR_CLUSTER_SIZE: cluster_size_in = csr_wdata[fcd_pkg::SIZE_W-1:0];
            fcd_pkg::CSR_RECORD_LIMIT: record_limit_in = csr_wdata[fcd_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Cluster checks, evaluated on the last byte of a cluster.
   always_comb begin
      if (cluster_size_ff < fcd_pkg::SIZE_W'(fcd_pkg::SIZE_MIN)) begin
         size_eff = fcd_pkg::SIZE_W'(fcd_pkg::SIZE_MIN);
      end else if (cluster_size_ff > fcd_pkg::SIZE_W'(fcd_pkg::SIZE_HI)) begin
         size_eff = fcd_pkg::SIZE_W'(fcd_pkg::SIZE_HI);
      end else begin
         size_eff = cluster_size_ff;
      end
      dsize       = size_eff - fcd_pkg::SIZE_W'(fcd_pkg::HDR_BYTES);
      pos_plus    = fcd_pkg::CMP_W'(pos_ff) + fcd_pkg::CMP_W'(1);
      cluster_end = pos_plus >= fcd_pkg::CMP_W'(size_eff);
      sum_new     = sum_ff + req_data.data_byte;

      used_ok  = !hdr_used_ff[7] && (hdr_used_ff[6:0] <= dsize);
      is_first = (hdr_index_ff == 8'd1) && (hdr_count_ff != 8'd0) && !hdr_count_ff[7]
                 && used_ok;
      is_valid = (sum_new == 8'd0) &&
                 (is_first || ((hdr_index_ff == exp_index_ff) &&
                               (hdr_count_ff == rec_clusters_ff) && used_ok));
      is_nul   = (hdr_index_ff == 8'd0) && (hdr_count_ff == 8'd0);
      is_last  = is_valid && (hdr_index_ff == hdr_count_ff);

      // A first cluster opens a new record before the copy decision.
      rec_eff  = is_first || in_record_ff;
      base_eff = is_first ? 16'd0 : gathered_ff;

      // A gathered count above the limit leaves a negative room, which still counts as a fit.
      room    = {1'b0, record_limit_ff} - {1'b0, base_eff};
      fits    = room[16] || (room[15:0] >= {8'd0, hdr_used_ff});
      do_copy = is_valid && rec_eff && fits;
      do_over = is_valid && rec_eff && !fits;
      emit_data      = do_copy && (hdr_used_ff != 8'd0);
      gathered_after = base_eff + {8'd0, hdr_used_ff};
   end

   // Next state, buffer write and job generation.
   always_comb begin
      pos_in          = pos_ff;
      sum_in          = sum_ff;
      exp_index_in    = exp_index_ff;
      rec_clusters_in = rec_clusters_ff;
      in_record_in    = in_record_ff;
      gathered_in     = gathered_ff;
      bank_in         = bank_ff;
      hdr_index_in    = hdr_index_ff;
      hdr_count_in    = hdr_count_ff;
      hdr_used_in     = hdr_used_ff;

      ram_wr.we   = accept && (req_data.action == fcd_pkg::ACT_BYTE);
      ram_wr.addr = {bank_ff, pos_ff};
      ram_wr.data = req_data.data_byte;

      job_push         = 1'b0;
      job.bank         = bank_ff;
      job.copy_cnt     = '0;
      job.base_offset  = base_eff;
      job.has_status   = 1'b0;
      job.status       = fcd_pkg::ST_COMPLETE;
      job.length       = 16'd0;

      if (accept && (req_data.action == fcd_pkg::ACT_EOS)) begin
         // End of stream drops any partial cluster and ends the read.
         job_push        = 1'b1;
         job.has_status  = 1'b1;
         job.status      = fcd_pkg::ST_EOS;
         pos_in          = '0;
         sum_in          = 8'd0;
         exp_index_in    = 8'd0;
         rec_clusters_in = 8'd0;
         in_record_in    = 1'b0;
         gathered_in     = 16'd0;
      end else if (accept) begin
         // Header bytes are kept aside for the checks.
         if (pos_ff == fcd_pkg::POS_W'(0)) hdr_index_in = req_data.data_byte;
         if (pos_ff == fcd_pkg::POS_W'(1)) hdr_count_in = req_data.data_byte;
         if (pos_ff == fcd_pkg::POS_W'(2)) hdr_used_in  = req_data.data_byte;

         if (!cluster_end) begin
            pos_in = pos_ff + fcd_pkg::POS_W'(1);
            sum_in = sum_new;
         end else begin
            pos_in = '0;
            sum_in = 8'd0;

            if (is_first) begin
               exp_index_in    = 8'd1;
               rec_clusters_in = hdr_count_ff;
               in_record_in    = 1'b1;
               gathered_in     = 16'd0;
            end

            if (do_copy) begin
               gathered_in  = gathered_after;
               exp_index_in = (is_first ? 8'd1 : exp_index_ff) + 8'd1;
            end else if (!(is_valid && rec_eff) && !is_nul) begin
               in_record_in = 1'b0;
            end

            if (do_over || is_last) begin
               pos_in          = '0;
               sum_in          = 8'd0;
               exp_index_in    = 8'd0;
               rec_clusters_in = 8'd0;
               in_record_in    = 1'b0;
               gathered_in     = 16'd0;
            end

            job.copy_cnt   = do_copy ? hdr_used_ff[fcd_pkg::POS_W-1:0] : '0;
            job.has_status = do_over || is_last;
            job.status     = do_over ? fcd_pkg::ST_OVERFLOW : fcd_pkg::ST_COMPLETE;
            job.length     = do_over ? 16'd0 : (do_copy ? gathered_after : base_eff);
            job_push       = emit_data || do_over || is_last;

            // The bank flips only when the back will read this cluster's data.
            if (emit_data) begin
               bank_in = bank_ff + 1'b1;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_size_ff <= fcd_pkg::CLUSTER_SIZE_RESET;
         record_limit_ff <= fcd_pkg::RECORD_LIMIT_RESET;
         pos_ff          <= '0;
         sum_ff          <= 8'd0;
         exp_index_ff    <= 8'd0;
         rec_clusters_ff <= 8'd0;
         in_record_ff    <= 1'b0;
         gathered_ff     <= 16'd0;
         bank_ff         <= '0;
      end else begin
         cluster_size_ff <= cluster_size_in;
         record_limit_ff <= record_limit_in;
         pos_ff          <= pos_in;
         sum_ff          <= sum_in;
         exp_index_ff    <= exp_index_in;
         rec_clusters_ff <= rec_clusters_in;
         in_record_ff    <= in_record_in;
         gathered_ff     <= gathered_in;
         bank_ff         <= bank_in;
      end
   end

   // Header capture.
   always_ff @(posedge clock) begin
      hdr_index_ff <= hdr_index_in;
      hdr_count_ff <= hdr_count_in;
      hdr_used_ff  <= hdr_used_in;
   end

endmodule

[design/fcd_job_queue.sv]
`include "assert_macros.svh"

module fcd_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fcd_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output fcd_pkg::job_type head_job
);

   fcd_pkg::job_type            slot_ff [fcd_pkg::QUEUE_DEPTH];
   logic [fcd_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [fcd_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [fcd_pkg::QCNT_W-1:0]  count_ff, count_in;

   assign full       = count_ff == fcd_pkg::QCNT_W'(fcd_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fcd_pkg::QPTR_W'(fcd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + fcd_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == fcd_pkg::QPTR_W'(fcd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + fcd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + fcd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - fcd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_NEVER(a_queue_overrun, push && full && !pop, "job pushed into a full queue")
   `ASSERT_NEVER(a_queue_underrun, pop && !head_valid, "job popped from an empty queue")

endmodule

[design/fcd_back.sv]
`include "assert_macros.svh"

module fcd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  fcd_pkg::job_type             head_job,
   output logic                         job_pop,
   output logic                         ram_re,
   output logic [fcd_pkg::ADDR_W-1:0]   ram_raddr,
   input  logic [7:0]                   ram_rdata,
   output logic                         empty,
   input  logic                         pop,
   output fcd_pkg::rsp_type             rsp_data
);

   logic                       out_valid_ff, out_valid_in;
   logic [fcd_pkg::POS_W-1:0]  idx_ff, idx_in;
   fcd_pkg::rsp_type           meta_ff, meta_in;

   logic                       advance;
   logic                       issue;
   logic                       is_data;
   logic                       data_last;
   logic [fcd_pkg::POS_W-1:0]  idx_next;

   // The output slot frees when it is empty or its beat is taken this cycle.
   always_comb begin
      advance   = !out_valid_ff || pop;
      issue     = advance && head_valid;
      is_data   = idx_ff < head_job.copy_cnt;
      idx_next  = idx_ff + fcd_pkg::POS_W'(1);
      data_last = (idx_next == head_job.copy_cnt) && !head_job.has_status;

      ram_re    = issue && is_data;
      ram_raddr = {head_job.bank, fcd_pkg::POS_W'(fcd_pkg::HDR_BYTES) + idx_ff};
      job_pop   = issue && (is_data ? data_last : 1'b1);

      idx_in = idx_ff;
      if (issue) begin
         idx_in = job_pop ? '0 : idx_next;
      end

      out_valid_in = out_valid_ff;
      if (issue) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end

      // Result fields other than the byte, which comes from the buffer read register.
      meta_in = meta_ff;
      if (issue) begin
         meta_in.out_byte = 8'd0;
         if (is_data) begin
            meta_in.kind          = fcd_pkg::KIND_DATA;
            meta_in.record_offset = head_job.base_offset + 16'(idx_ff);
            meta_in.status        = fcd_pkg::ST_COMPLETE;
            meta_in.record_length = 16'd0;
            meta_in.last          = data_last;
         end else begin
            meta_in.kind          = fcd_pkg::KIND_STATUS;
            meta_in.record_offset = 16'd0;
            meta_in.status        = head_job.status;
            meta_in.record_length = head_job.length;
            meta_in.last          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff <= meta_in;
   end

   assign empty = !out_valid_ff;

   always_comb begin
      rsp_data          = meta_ff;
      rsp_data.out_byte = (meta_ff.kind == fcd_pkg::KIND_DATA) ? ram_rdata : 8'd0;
   end

   `ASSERT_ALWAYS(a_idx_in_job, head_valid |-> idx_ff <= head_job.copy_cnt, "beat index past job")
   `ASSERT_ALWAYS(a_idx_idle, !head_valid |-> idx_ff == '0, "beat index left over without a job")
   `ASSERT_ALWAYS(a_job_nonempty, head_valid |-> (head_job.copy_cnt != '0) || head_job.has_status,
                  "job without any result")
   `ASSERT_ALWAYS(a_status_last, out_valid_ff && (meta_ff.kind == fcd_pkg::KIND_STATUS) |->
                  meta_ff.last, "status beat not marked last")

endmodule

[design/flash_record_cluster_deframer.sv]
// Channel  Handshake              Payload
// req      push / full            req_data (action, data_byte)
// rsp      empty / pop            rsp_data (kind, out_byte, record_offset, status,
//                                           record_length, last)
// csr      csr_valid / csr_ready  csr_index, csr_wdata
//
// One byte is taken per cycle while the job queue has a free slot; the two-entry queue
// matches the two banks of the cluster buffer, so input stalls only when two jobs (checked
// clusters with results, or an end of stream) still wait for the result side. The back
// issues one beat per cycle unless its output stalls, from the single read port: a copied
// cluster with N used bytes gives N data beats plus one status beat when it ends the read.
// End of stream yields one status beat. Reset is synchronous and needs no clearing pass.
module flash_record_cluster_deframer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  fcd_pkg::req_type               req_data,
   output logic                           empty,
   input  logic                           pop,
   output fcd_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fcd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic                          accept;
   logic                          job_push;
   fcd_pkg::job_type              push_job;
   logic                          job_pop;
   logic                          head_valid;
   fcd_pkg::job_type              head_job;
   fcd_pkg::ram_wr_type           ram_wr;
   logic                          ram_re;
   logic [fcd_pkg::ADDR_W-1:0]    ram_raddr;
   logic [7:0]                    ram_rdata;
   logic                          rsp_pop;

   assign accept  = push && !full;
   assign rsp_pop = pop && !empty;

   // Front: receives cluster bytes and checks each cluster.
   fcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .job_push  (job_push),
      .job       (push_job),
      .ram_wr    (ram_wr)
   );

   // Cluster buffer, one bank per cluster in flight.
   fcd_ram #(
      .WIDTH (8),
      .DEPTH (fcd_pkg::BANKS * fcd_pkg::CLUSTER_MAX)
   ) u_ram (
      .clock (clock),
      .we    (ram_wr.we),
      .waddr (ram_wr.addr),
      .wdata (ram_wr.data),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Jobs between the front and the back.
   fcd_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Back: plays out data beats and status beats.
   fcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .job_pop    (job_pop),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .empty      (empty),
      .pop        (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
